FILE: src/flow_shop_completion_update_top_assert.svh
// ---------------------------------------------------------------------------
// flow shop completion update - assertion macros
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef FLOW_SHOP_COMPLETION_UPDATE_TOP_ASSERT_SVH
`define FLOW_SHOP_COMPLETION_UPDATE_TOP_ASSERT_SVH

// same-cycle implication
`define FSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fsc_pkg.sv
// ---------------------------------------------------------------------------
// fsc_pkg
// shared widths, codes, command/status types and helpers
// ---------------------------------------------------------------------------
package fsc_pkg;

    localparam int MACHINES_DEF = 8;
    localparam int MACH_W       = 3;
    localparam int PROC_W       = 16;
    localparam int TIME_W       = 32;
    localparam int MASK_W       = 64;

    localparam logic KIND_BOTTOM = 1'b0;
    localparam logic KIND_TOP    = 1'b1;

    typedef struct packed {
        logic              load_item;
        logic              rd_scan;
        logic [MACH_W-1:0] rd_addr;
        logic              rd_own;
        logic              wr_back;
        logic              ld_out;
    } fsc_cmd_t;

    typedef struct packed {
        logic bad_machine;
        logic out_free;
    } fsc_status_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

FILE: src/fsc_if.sv
// ---------------------------------------------------------------------------
// fsc channel interfaces
// operation word in, result word out, precedence mask write
// ---------------------------------------------------------------------------
interface fsc_item_if
    import fsc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [MACH_W-1:0] machine;
    logic [PROC_W-1:0] proc_time;
    logic [TIME_W-1:0] boundary_time;

    modport source (output valid, kind, machine, proc_time, boundary_time, input ready);
    modport sink   (input valid, kind, machine, proc_time, boundary_time, output ready);
endinterface

interface fsc_result_if
    import fsc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [MACH_W-1:0] machine_out;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] load_total;

    modport source (output valid, machine_out, completion, load_total, input ready);
    modport sink   (input valid, machine_out, completion, load_total, output ready);
endinterface

interface fsc_cfg_if
    import fsc_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] pred_mask;

    modport source (output valid, pred_mask, input ready);
    modport sink   (input valid, pred_mask, output ready);
endinterface

FILE: src/fsc_datapath.sv
// ---------------------------------------------------------------------------
// fsc_datapath
// item latch, state memories, neighbour maximum, saturating update, output word
// ---------------------------------------------------------------------------
module fsc_datapath
    import fsc_pkg::*;
#(
    parameter int MACHINES = MACHINES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  fsc_cmd_t          cmd,
    output fsc_status_t       status,
    input  logic              kind,
    input  logic [MACH_W-1:0] machine,
    input  logic [PROC_W-1:0] proc_time,
    input  logic [TIME_W-1:0] boundary_time,
    input  logic              cfg_valid,
    input  logic [MASK_W-1:0] pred_mask,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [MACH_W-1:0] machine_out,
    output logic [TIME_W-1:0] completion,
    output logic [TIME_W-1:0] load_total
);

    localparam int IDX_W = (MACHINES > 1) ? $clog2(MACHINES) : 1;

    logic              kind_reg;
    logic [MACH_W-1:0] mach_reg;
    logic [PROC_W-1:0] pt_reg;
    logic [TIME_W-1:0] bt_reg;
    logic [MASK_W-1:0] mask_reg;

    logic [TIME_W-1:0] ct_mem [MACHINES];
    logic [TIME_W-1:0] lt_mem [MACHINES];
    logic [MACHINES-1:0] vld_reg;

    logic [TIME_W-1:0] rd_ct_reg;
    logic [TIME_W-1:0] rd_lt_reg;
    logic              hit_reg;
    logic              scan_vld_reg;
    logic              any_reg;
    logic [TIME_W-1:0] nb_reg;
    logic [TIME_W-1:0] res_ct_reg;
    logic [TIME_W-1:0] res_lt_reg;

    logic              out_valid_reg;
    logic [MACH_W-1:0] out_mach_reg;
    logic [TIME_W-1:0] out_ct_reg;
    logic [TIME_W-1:0] out_lt_reg;

    logic [IDX_W-1:0]  rd_idx;
    logic [IDX_W-1:0]  own_idx;
    logic [5:0]        edge_idx;
    logic              bad;
    logic [TIME_W-1:0] nb_eff;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] ct_next;
    logic [TIME_W-1:0] lt_next;

    assign own_idx = mach_reg[IDX_W-1:0];
    assign rd_idx  = cmd.rd_own ? own_idx : cmd.rd_addr[IDX_W-1:0];
    assign bad     = ({1'b0, mach_reg} >= (MACH_W+1)'(MACHINES));

    // bit to*8+from of the mask
    assign edge_idx = (kind_reg == KIND_TOP) ? {cmd.rd_addr, mach_reg}
                                             : {mach_reg, cmd.rd_addr};

    assign nb_eff  = any_reg ? nb_reg : bt_reg;
    assign base    = (rd_ct_reg > nb_eff) ? rd_ct_reg : nb_eff;
    assign ct_next = sat_add(base, {{(TIME_W-PROC_W){1'b0}}, pt_reg});
    assign lt_next = sat_add(rd_lt_reg, {{(TIME_W-PROC_W){1'b0}}, pt_reg});

    assign status.bad_machine = bad;
    assign status.out_free    = !out_valid_reg || out_ready;

    // item payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= kind;
            mach_reg <= machine;
            pt_reg   <= proc_time;
            bt_reg   <= boundary_time;
        end
    end

    // precedence mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (cfg_valid)
            mask_reg <= pred_mask;
    end

    // state memories, registered read, unwritten entries read as zero
    always_ff @(posedge clk)
    begin
        if (cmd.rd_scan || cmd.rd_own)
        begin
            rd_ct_reg <= vld_reg[rd_idx] ? ct_mem[rd_idx] : '0;
            rd_lt_reg <= vld_reg[rd_idx] ? lt_mem[rd_idx] : '0;
        end
        if (cmd.wr_back)
        begin
            ct_mem[own_idx] <= ct_next;
            lt_mem[own_idx] <= lt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (cmd.wr_back)
            vld_reg[own_idx] <= 1'b1;
    end

    // neighbour scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_vld_reg <= 1'b0;
            any_reg      <= 1'b0;
        end
        else
        begin
            scan_vld_reg <= cmd.rd_scan;
            if (cmd.load_item)
                any_reg <= 1'b0;
            else if (scan_vld_reg && hit_reg)
                any_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_scan)
            hit_reg <= mask_reg[edge_idx];
        if (cmd.load_item)
            nb_reg <= '0;
        else if (scan_vld_reg && hit_reg && (rd_ct_reg > nb_reg))
            nb_reg <= rd_ct_reg;
        if (cmd.wr_back)
        begin
            res_ct_reg <= ct_next;
            res_lt_reg <= lt_next;
        end
    end

    // output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.ld_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_out)
        begin
            out_mach_reg <= mach_reg;
            out_ct_reg   <= bad ? '0 : res_ct_reg;
            out_lt_reg   <= bad ? '0 : res_lt_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign machine_out = out_mach_reg;
    assign completion  = out_ct_reg;
    assign load_total  = out_lt_reg;

`include "flow_shop_completion_update_top_assert.svh"

    // completion never falls behind the accumulated load
    `FSC_ASSERT_NOW(a_ct_ge_lt, out_valid_reg, out_ct_reg >= out_lt_reg, "completion below load")

endmodule

FILE: src/fsc_ctrl.sv
// ---------------------------------------------------------------------------
// fsc_ctrl
// sequencer: accept, neighbour scan, own read, write back, result hand-off
// ---------------------------------------------------------------------------
module fsc_ctrl
    import fsc_pkg::*;
#(
    parameter int MACHINES = MACHINES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  fsc_status_t status,
    output fsc_cmd_t    cmd
);

    localparam int IDX_W = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MACHINES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OWN,
        S_CALC,
        S_PUT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] j_next;

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        cmd        = '0;
        cmd.rd_addr = MACH_W'(j_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_item = item_valid;
                j_next        = '0;
                if (item_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (status.bad_machine)
                    state_next = S_PUT;
                else
                begin
                    cmd.rd_scan = 1'b1;
                    if (j_reg == LAST_IDX)
                        state_next = S_OWN;
                    else
                        j_next = j_reg + 1'b1;
                end
            end
            S_OWN:
            begin
                cmd.rd_own = 1'b1;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                cmd.wr_back = 1'b1;
                state_next  = S_PUT;
            end
            S_PUT:
            begin
                cmd.ld_out = status.out_free;
                if (status.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

`include "flow_shop_completion_update_top_assert.svh"

    `FSC_ASSERT_NEXT(a_accept_busy, item_valid && item_ready, state_reg == S_SCAN, "accept lost")
    `FSC_ASSERT_NOW(a_scan_range, state_reg == S_SCAN, j_reg <= LAST_IDX, "scan index past end")
    `FSC_ASSERT_NEXT(a_put_done, state_reg == S_PUT && status.out_free, state_reg == S_IDLE,
        "result not handed off")

endmodule

FILE: src/flow_shop_completion_update_top.sv
// ---------------------------------------------------------------------------
// flow_shop_completion_update_top
// per-machine completion time and load update for a partial flow-shop sequence
// ---------------------------------------------------------------------------
// An operation word is not followed by another until it has run every step: the
// completion times of all machines are read one per cycle through the single
// read port of the state memory to form the neighbour maximum, then the
// machine's own entry is read, updated and written back, and the result is
// handed to the output register once that is free. A word for a machine index
// at or above MACHINES skips the scan and returns zeros. The result sits in an
// output register, so the next word is taken while the result waits; the
// precedence mask write is always ready and is registered.
module flow_shop_completion_update_top
    import fsc_pkg::*;
#(
    parameter int MACHINES = MACHINES_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    fsc_item_if.sink     item,
    fsc_result_if.source result,
    fsc_cfg_if.sink      cfg
);

    fsc_cmd_t    cmd;
    fsc_status_t status;
    logic        ctl_ready;

    fsc_ctrl #(
        .MACHINES (MACHINES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (ctl_ready),
        .status     (status),
        .cmd        (cmd)
    );

    fsc_datapath #(
        .MACHINES (MACHINES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .kind          (item.kind),
        .machine       (item.machine),
        .proc_time     (item.proc_time),
        .boundary_time (item.boundary_time),
        .cfg_valid     (cfg.valid),
        .pred_mask     (cfg.pred_mask),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .machine_out   (result.machine_out),
        .completion    (result.completion),
        .load_total    (result.load_total)
    );

    assign item.ready = ctl_ready;
    assign cfg.ready  = 1'b1;

endmodule
